FILE: sv/pc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pc_pkg;

    typedef enum logic [3:0] {
        OP_NSXX,
        OP_SXSX,
        OP_NSYY,
        OP_SYSY,
        OP_NSXY,
        OP_SXSY,
        OP_AB,
        OP_NUM2,
        OP_SEARCH
    } op_t;

    typedef struct packed {
        logic acc_en;
        logic start;
        op_t  op;
        logic search_init;
        logic mid_en;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic undef;
        logic search_done;
    } status_t;

    localparam logic [15:0] Q_INIT_HI = 16'h8000;
    localparam logic [15:0] Q_MAX_POS = 16'h7FFF;

endpackage
`default_nettype wire

FILE: sv/pearson_correlation_top.sv
// Pearson correlation of two paired sample streams.
// The input channel (in_valid, in_ready) carries one item per pair: x_sample,
// y_sample and last_pair. Pairs are accumulated at one item per cycle.
// The item with last_pair set ends a vector; the block then stops taking
// items and works out r with a shared shift-add multiplier that retires one
// multiplier bit per cycle. The work is six products, then two wide products
// and up to 16 square root search passes. A zero variance ends the work
// before the wide products.
// The output channel (out_valid, out_ready) carries correlation in Q1.15,
// undefined and pair_count from an output register, so accumulation of the
// next vector goes on while a result waits. A stalled receiver only holds
// the block once a second result is ready.
// Pairs beyond MAX_PAIRS in a vector are dropped from the sums.
// Reset clears the sums, the count and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation_top
    import pc_pkg::*;
#(
    parameter int MAX_PAIRS   = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] x_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] y_sample,
    input  wire logic                          last_pair,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [15:0]                 correlation,
    output logic                               undefined,
    output logic [$clog2(MAX_PAIRS+1)-1:0]     pair_count
);

    cmd_t    cmd;
    status_t status;

    pc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_pair (last_pair),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pc_datapath #(
        .MAX_PAIRS   (MAX_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       ($clog2(MAX_PAIRS + 1))
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .x_sample    (x_sample),
        .y_sample    (y_sample),
        .cmd         (cmd),
        .status      (status),
        .correlation (correlation),
        .undefined   (undefined),
        .pair_count  (pair_count)
    );

endmodule
`default_nettype wire

FILE: sv/pc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pc_ctrl
    import pc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    last_pair,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_ACC   = 6'b000001,
        S_START = 6'b000010,
        S_WAIT  = 6'b000100,
        S_CHECK = 6'b001000,
        S_MID   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_ACC);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = op_reg;
        unique case (state_reg)
            S_ACC:
            begin
                cmd.acc_en = in_valid;
                if (in_valid && last_pair)
                begin
                    op_next    = OP_NSXX;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.mul_done)
                begin
                    unique case (op_reg)
                        OP_NSXX: begin op_next = OP_SXSX; state_next = S_START; end
                        OP_SXSX: begin op_next = OP_NSYY; state_next = S_START; end
                        OP_NSYY: begin op_next = OP_SYSY; state_next = S_START; end
                        OP_SYSY: begin op_next = OP_NSXY; state_next = S_START; end
                        OP_NSXY: begin op_next = OP_SXSY; state_next = S_START; end
                        OP_SXSY: state_next = S_CHECK;
                        OP_AB:   begin op_next = OP_NUM2; state_next = S_START; end
                        default: state_next = S_MID;
                    endcase
                end
            end
            S_CHECK:
            begin
                cmd.search_init = 1'b1;
                if (status.undef)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    op_next    = OP_AB;
                    state_next = S_START;
                end
            end
            S_MID:
            begin
                if (status.search_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.mid_en = 1'b1;
                    op_next    = OP_SEARCH;
                    state_next = S_START;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_ACC;
                end
            end
            default: state_next = S_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            op_reg        <= OP_NSXX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/pc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module pc_datapath
    import pc_pkg::*;
#(
    parameter int MAX_PAIRS   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_W       = $clog2(MAX_PAIRS + 1)
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [SAMPLE_BITS-1:0] x_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] y_sample,
    input  wire cmd_t                          cmd,
    output status_t                            status,
    output logic signed [15:0]                 correlation,
    output logic                               undefined,
    output logic [CNT_W-1:0]                   pair_count
);

    localparam int SX_W = SAMPLE_BITS + CNT_W;
    localparam int SQ_W = 2 * SAMPLE_BITS + CNT_W;
    localparam int VW   = 2 * SX_W + 2;
    localparam int PW   = 4 * SX_W + 34;
    localparam int BW   = (VW > 32) ? VW : 32;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAIRS);

    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SX_W-1:0]  sx_reg, sy_reg;
    logic signed [SQ_W-1:0]  sxx_reg, syy_reg, sxy_reg;
    logic signed [VW-1:0]    t1_reg, va_reg, vb_reg, num_reg;
    logic [PW-1:0]           ab_reg, rhs_reg;
    logic [PW-1:0]           ma_reg;
    logic [BW-1:0]           mb_reg;
    logic [PW-1:0]           acc_reg;
    logic                    msign_reg;
    logic                    busy_reg;
    op_t                     mop_reg;
    logic [15:0]             lo_reg, hi_reg, mid_reg;
    logic [31:0]             osq_reg;
    logic signed [15:0]      corr_reg;
    logic                    undef_reg;
    logic [CNT_W-1:0]        pcnt_reg;

    logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;
    logic [SX_W-1:0]         sx_mag, sy_mag;
    logic [SQ_W-1:0]         sxy_mag;
    logic [VW-1:0]           num_mag;
    logic [PW-1:0]           a_sel;
    logic [BW-1:0]           b_sel;
    logic                    s_sel;
    logic signed [PW:0]      prod;
    logic signed [VW-1:0]    prod_v;
    logic                    mul_done;
    logic [16:0]             mid_sum;
    logic [15:0]             mid;
    logic [15:0]             odd;

    assign xx = x_sample * x_sample;
    assign yy = y_sample * y_sample;
    assign xy = x_sample * y_sample;

    assign sx_mag  = sx_reg[SX_W-1] ? SX_W'(-sx_reg) : SX_W'(sx_reg);
    assign sy_mag  = sy_reg[SX_W-1] ? SX_W'(-sy_reg) : SX_W'(sy_reg);
    assign sxy_mag = sxy_reg[SQ_W-1] ? SQ_W'(-sxy_reg) : SQ_W'(sxy_reg);
    assign num_mag = num_reg[VW-1] ? VW'(-num_reg) : VW'(num_reg);

    always_comb
    begin
        a_sel = '0;
        b_sel = '0;
        s_sel = 1'b0;
        unique case (cmd.op)
            OP_NSXX:   begin a_sel = PW'(unsigned'(sxx_reg)); b_sel = BW'(cnt_reg); end
            OP_SXSX:   begin a_sel = PW'(sx_mag); b_sel = BW'(sx_mag); end
            OP_NSYY:   begin a_sel = PW'(unsigned'(syy_reg)); b_sel = BW'(cnt_reg); end
            OP_SYSY:   begin a_sel = PW'(sy_mag); b_sel = BW'(sy_mag); end
            OP_NSXY:
            begin
                a_sel = PW'(sxy_mag);
                b_sel = BW'(cnt_reg);
                s_sel = sxy_reg[SQ_W-1];
            end
            OP_SXSY:
            begin
                a_sel = PW'(sx_mag);
                b_sel = BW'(sy_mag);
                s_sel = sx_reg[SX_W-1] ^ sy_reg[SX_W-1];
            end
            OP_AB:     begin a_sel = PW'(unsigned'(va_reg)); b_sel = BW'(unsigned'(vb_reg)); end
            OP_NUM2:   begin a_sel = PW'(num_mag); b_sel = BW'(num_mag); end
            OP_SEARCH: begin a_sel = ab_reg; b_sel = BW'(osq_reg); end
            default:   begin a_sel = '0; b_sel = '0; end
        endcase
    end

    assign mul_done = busy_reg && (mb_reg == '0);
    assign prod     = msign_reg ? -signed'({1'b0, acc_reg}) : signed'({1'b0, acc_reg});
    assign prod_v   = prod[VW-1:0];

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1;
    assign mid     = mid_sum[16:1];
    assign odd     = 16'({1'b0, mid, 1'b0} - 18'd1);

    assign status.mul_done    = mul_done;
    assign status.undef       = va_reg[VW-1] || (va_reg == '0)
                             || vb_reg[VW-1] || (vb_reg == '0);
    assign status.search_done = (lo_reg >= hi_reg);

    assign correlation = corr_reg;
    assign undefined   = undef_reg;
    assign pair_count  = pcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sxx_reg  <= '0;
            syy_reg  <= '0;
            sxy_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                cnt_reg <= '0;
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxx_reg <= '0;
                syy_reg <= '0;
                sxy_reg <= '0;
            end
            else if (cmd.acc_en && (cnt_reg < MAX_CNT))
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sx_reg  <= sx_reg + SX_W'(x_sample);
                sy_reg  <= sy_reg + SX_W'(y_sample);
                sxx_reg <= sxx_reg + SQ_W'(xx);
                syy_reg <= syy_reg + SQ_W'(yy);
                sxy_reg <= sxy_reg + SQ_W'(xy);
            end
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (mul_done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ma_reg    <= a_sel;
            mb_reg    <= b_sel;
            acc_reg   <= '0;
            msign_reg <= s_sel;
            mop_reg   <= cmd.op;
        end
        else if (busy_reg && !mul_done)
        begin
            if (mb_reg[0])
            begin
                acc_reg <= acc_reg + ma_reg;
            end
            ma_reg <= {ma_reg[PW-2:0], 1'b0};
            mb_reg <= {1'b0, mb_reg[BW-1:1]};
        end

        if (mul_done)
        begin
            unique case (mop_reg)
                OP_NSXX, OP_NSYY, OP_NSXY: t1_reg <= prod_v;
                OP_SXSX:   va_reg  <= t1_reg - prod_v;
                OP_SYSY:   vb_reg  <= t1_reg - prod_v;
                OP_SXSY:   num_reg <= t1_reg - prod_v;
                OP_AB:     ab_reg  <= acc_reg;
                OP_NUM2:   rhs_reg <= {acc_reg[PW-33:0], 32'd0};
                OP_SEARCH:
                begin
                    if (acc_reg <= rhs_reg)
                    begin
                        lo_reg <= mid_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg - 16'd1;
                    end
                end
                default: t1_reg <= t1_reg;
            endcase
        end

        if (cmd.search_init)
        begin
            lo_reg <= '0;
            hi_reg <= Q_INIT_HI;
        end

        if (cmd.mid_en)
        begin
            mid_reg <= mid;
            osq_reg <= odd * odd;
        end

        if (cmd.finish)
        begin
            pcnt_reg  <= cnt_reg;
            undef_reg <= status.undef;
            if (status.undef)
            begin
                corr_reg <= '0;
            end
            else if (num_reg[VW-1])
            begin
                corr_reg <= signed'(16'(~lo_reg + 16'd1));
            end
            else if (lo_reg > Q_MAX_POS)
            begin
                corr_reg <= signed'(Q_MAX_POS);
            end
            else
            begin
                corr_reg <= signed'(lo_reg);
            end
        end
    end

endmodule
`default_nettype wire
